// ----- rtl/busdec_pkg.sv -----
package busdec_pkg;

   // Address bus and data widths
   localparam int unsigned ADDR_W   = 24;
   localparam int unsigned DATA_W   = 16;
   localparam int unsigned CSR_AW   = 5;
   localparam int unsigned CSR_DW   = 32;
   localparam int unsigned REQ_DW   = 40;
   localparam int unsigned REQ_UW   = 2;
   localparam int unsigned RSP_DW   = 72;

   // Reset values of the control registers
   localparam logic [ADDR_W-1:0] RAM_SIZE_RESET       = 24'h100000;
   localparam logic              FAULT_CHECK_ON_RESET = 1'b1;

   // Device selected by an access
   typedef enum logic [3:0] {
      TGT_NONE     = 4'd0,
      TGT_RAM      = 4'd1,
      TGT_MEMCFG   = 4'd2,
      TGT_DMA_ADDR = 4'd3,
      TGT_DMA_DISK = 4'd4,
      TGT_DMA_STAT = 4'd5,
      TGT_PSG_SEL  = 4'd6,
      TGT_PSG_DATA = 4'd7,
      TGT_ACIA0    = 4'd8,
      TGT_ACIA1    = 4'd9,
      TGT_RTC      = 4'd10
   } target_type;

   // Control register indexes (byte address is 4 * index)
   typedef enum logic [2:0] {
      CSR_RAM_SIZE       = 3'd0,
      CSR_FAULT_CHECK_ON = 3'd1,
      CSR_IS_STE         = 3'd2,
      CSR_IS_MEGA        = 3'd3,
      CSR_IS_TT          = 3'd4,
      CSR_HAS_RTC        = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [ADDR_W-1:0] ram_size;
      logic              fault_check_on;
      logic              is_ste;
      logic              is_mega;
      logic              is_tt;
      logic              has_rtc;
   } cfg_type;

   typedef struct packed {
      logic              kind;
      logic              is_word;
      logic [ADDR_W-1:0] address;
      logic [DATA_W-1:0] write_data;
   } req_item_type;

   typedef struct packed {
      target_type        target;
      logic [3:0]        reg_index;
      logic [ADDR_W-1:0] ram_offset;
      logic [DATA_W-1:0] local_data;
      logic [DATA_W-1:0] device_data;
      logic              high_lane;
      logic              access_fault;
   } rsp_item_type;

endpackage

// ----- rtl/busdec_decode.sv -----
module busdec_decode
   import busdec_pkg::*;
(
   input  req_item_type item,
   input  cfg_type      cfg,
   input  logic [7:0]   mem_config,
   output rsp_item_type result,
   output logic         memcfg_we,
   output logic [7:0]   memcfg_wdata
);

   // Upper limit of each memory-bank setting
   function automatic logic [ADDR_W-1:0] bank_limit(input logic [3:0] sel);
      logic [ADDR_W-1:0] lim;
      unique case (sel)
         4'd0:    lim = 24'h040000;
         4'd1:    lim = 24'h080000;
         4'd2:    lim = 24'h200000;
         4'd3:    lim = 24'h800000;
         4'd4:    lim = 24'h080000;
         4'd5:    lim = 24'h100000;
         4'd6:    lim = 24'h280000;
         4'd7:    lim = 24'h880000;
         4'd8:    lim = 24'h200000;
         4'd9:    lim = 24'h280000;
         4'd10:   lim = 24'h400000;
         4'd11:   lim = 24'ha00000;
         4'd12:   lim = 24'h800000;
         4'd13:   lim = 24'h880000;
         4'd14:   lim = 24'ha00000;
         default: lim = 24'hf00000;
      endcase
      return lim;
   endfunction

   logic [ADDR_W-1:0] a;
   logic [DATA_W-1:0] wd;
   logic [7:0]        wbyte;
   logic [7:0]        whigh;
   logic              wr;
   logic              word;
   logic              below_size;
   logic              limit_ok;
   logic              in_sound;
   logic              in_blit;
   logic              in_rtc;
   logic              in_acia;
   logic              in_vme;
   logic              ste_byte;
   logic              ste_word;
   logic              acia_hi;
   target_type        acia_tgt;

   assign a     = item.address;
   assign wd    = item.write_data;
   assign wbyte = wd[7:0];
   assign whigh = wd[15:8];
   assign wr    = item.kind;
   assign word  = item.is_word;

   // Window checks used by the access kinds below
   assign below_size = a < cfg.ram_size;
   assign limit_ok   = (mem_config[7:4] == 4'd0) && (a < bank_limit(mem_config[3:0]));
   assign in_sound   = a[23:6] == 18'h3fe24;   // 0xff8900..0xff893f
   assign in_blit    = a[23:6] == 18'h3fe28;   // 0xff8a00..0xff8a3f
   assign in_rtc     = a[23:5] == 19'h7ffe1;   // 0xfffc20..0xfffc3f
   assign in_acia    = (a[23:3] == 21'h1fff80) && (a[2:0] != 3'd7) && !a[0];
   assign in_vme     = (a[23:4] == 20'hff8e0) && a[0];
   assign acia_hi    = a[2];
   assign acia_tgt   = acia_hi ? TGT_ACIA1 : TGT_ACIA0;

   // Enhanced-model sound and joypad registers
   assign ste_byte = (a == 24'hff9000) || (a == 24'hff9001) ||
                     (a[23:2] == 22'h3fe480) ||
                     (a == 24'hff9211) || (a == 24'hff9213) ||
                     (a == 24'hff9215) || (a == 24'hff9217) ||
                     (a[23:2] == 22'h3fe488);
   assign ste_word = (a == 24'hff9000) || (a == 24'hff9200) || (a == 24'hff9202) ||
                     (a == 24'hff9220) || (a == 24'hff9222);

   always_comb begin
      result       = '0;
      result.target = TGT_NONE;
      memcfg_we    = 1'b0;
      memcfg_wdata = wbyte;

      if (a < 24'hf00000) begin
         // RAM window with size and bank-limit check
         if (!below_size && cfg.fault_check_on && !limit_ok) begin
            result.access_fault = 1'b1;
            if (!wr) begin
               result.local_data = word ? 16'hffff : 16'h00ff;
            end
         end else if (below_size) begin
            result.target     = TGT_RAM;
            result.ram_offset = a;
            if (wr) begin
               result.device_data = word ? wd : {8'h00, wbyte};
            end
         end
      end else begin
         unique case ({wr, word})
            // Byte read
            2'b00: begin
               priority if (in_sound) result.access_fault = !cfg.is_ste;
               else if (in_blit) result.access_fault = 1'b1;
               else if (in_rtc) begin
                  if (cfg.is_mega || cfg.has_rtc) begin
                     result.target    = TGT_RTC;
                     result.reg_index = a[4:1];
                  end
               end
               else if (a == 24'hff8001) begin
                  result.target     = TGT_MEMCFG;
                  result.local_data = {8'h00, mem_config};
               end
               else if (a == 24'hff8609) result.target = TGT_DMA_ADDR;
               else if (a == 24'hff860b) begin
                  result.target    = TGT_DMA_ADDR;
                  result.reg_index = 4'd1;
               end
               else if (a == 24'hff860d) begin
                  result.target    = TGT_DMA_ADDR;
                  result.reg_index = 4'd2;
               end
               else if (a == 24'hff860e || a == 24'hff860f) begin
               end
               else if (a == 24'hff8800) result.target = TGT_PSG_DATA;
               else if (a == 24'hff8802) result.target = TGT_PSG_SEL;
               else if (in_acia) begin
                  result.target    = acia_tgt;
                  result.reg_index = {3'd0, a[1]};
               end
               else if (in_vme) result.access_fault = !(cfg.is_mega || cfg.is_tt);
               else if (ste_byte) result.access_fault = !cfg.is_ste;
               else result.access_fault = 1'b1;
            end
            // Word read
            2'b01: begin
               priority if (in_sound) result.access_fault = !cfg.is_ste;
               else if (in_blit) result.access_fault = 1'b1;
               else if (a == 24'hfa0000 || a == 24'hfa0002) begin
               end
               else if (a == 24'hff8604) result.target = TGT_DMA_DISK;
               else if (a == 24'hff8606) result.target = TGT_DMA_STAT;
               else if (a == 24'hff8608) result.target = TGT_DMA_ADDR;
               else if (a == 24'hff860a) begin
                  result.target    = TGT_DMA_ADDR;
                  result.reg_index = 4'd1;
               end
               else if (a == 24'hff860c) begin
                  result.target    = TGT_DMA_ADDR;
                  result.reg_index = 4'd2;
               end
               else if (a == 24'hff860e) begin
               end
               else if (ste_word) result.access_fault = !cfg.is_ste;
               else if (in_acia) begin
                  result.target    = acia_tgt;
                  result.reg_index = {3'd0, a[1]};
                  result.high_lane = 1'b1;
               end
               else result.access_fault = 1'b1;
            end
            // Byte write
            2'b10: begin
               priority if (a >= 24'hff8808 && a < 24'hff8900) result.access_fault = 1'b1;
               else if (in_sound) result.access_fault = !cfg.is_ste;
               else if (in_blit) result.access_fault = 1'b1;
               else if (in_rtc) begin
                  if (cfg.is_mega || cfg.has_rtc) begin
                     result.target      = TGT_RTC;
                     result.reg_index   = a[4:1];
                     result.device_data = {8'h00, wbyte};
                  end else begin
                     result.access_fault = 1'b1;
                  end
               end
               else if (a == 24'hff8001) begin
                  result.target      = TGT_MEMCFG;
                  result.device_data = {8'h00, wbyte};
                  memcfg_we          = 1'b1;
               end
               else if (a == 24'hff8609) begin
                  result.target      = TGT_DMA_ADDR;
                  result.device_data = {8'h00, wbyte};
               end
               else if (a == 24'hff860b) begin
                  result.target      = TGT_DMA_ADDR;
                  result.reg_index   = 4'd1;
                  result.device_data = {8'h00, wbyte};
               end
               else if (a == 24'hff860d) begin
                  result.target      = TGT_DMA_ADDR;
                  result.reg_index   = 4'd2;
                  result.device_data = {8'h00, wbyte};
               end
               else if (a == 24'hff860e || a == 24'hff860f) begin
               end
               else if (a == 24'hff8800 || a == 24'hff8804) begin
                  result.target      = TGT_PSG_SEL;
                  result.device_data = {8'h00, wbyte};
               end
               else if (a == 24'hff8802 || a == 24'hff8806) begin
                  result.target      = TGT_PSG_DATA;
                  result.device_data = {8'h00, wbyte};
               end
               else if (in_vme) result.access_fault = !cfg.is_mega;
               else if (ste_byte) result.access_fault = !cfg.is_ste;
               else if (in_acia) begin
                  result.target      = acia_tgt;
                  result.reg_index   = {3'd0, a[1]};
                  result.device_data = {8'h00, wbyte};
               end
               else result.access_fault = 1'b1;
            end
            // Word write
            default: begin
               priority if (a >= 24'hff8804 && a < 24'hff8900) result.access_fault = 1'b1;
               else if (in_sound) result.access_fault = !cfg.is_ste;
               else if (in_blit) result.access_fault = 1'b1;
               else if (a == 24'hff8604) begin
                  result.target      = TGT_DMA_DISK;
                  result.device_data = wd;
               end
               else if (a == 24'hff8606) begin
                  result.target      = TGT_DMA_STAT;
                  result.device_data = wd;
               end
               else if (a == 24'hff860e) begin
               end
               else if (a == 24'hff8800) begin
                  result.target      = TGT_PSG_SEL;
                  result.device_data = {8'h00, whigh};
               end
               else if (a == 24'hff8802) begin
                  result.target      = TGT_PSG_DATA;
                  result.device_data = {8'h00, whigh};
               end
               else if (ste_word) result.access_fault = !cfg.is_ste;
               else if (in_acia) begin
                  result.target      = acia_tgt;
                  result.reg_index   = {3'd0, a[1]};
                  result.device_data = {8'h00, whigh};
               end
               else result.access_fault = 1'b1;
            end
         endcase
      end
   end

endmodule

// ----- rtl/bus_address_decoder.sv -----
// Bus address decoder for a 24-bit CPU bus.
// Each request transfer carries one byte or word access (tuser: read/write and
// size; tdata: address and write data). Each response transfer carries the
// decoded target device, the register index inside it, the RAM offset, the
// read data the decoder supplies itself, the write data for the device, the
// upper-lane flag and the bus-error flag.
// The memory-configuration byte lives here; it is written and read back by
// byte accesses at 0xff8001, in request order.
// A request taken is held in the request register, decoded, and then held in
// the response register, which drives the response channel. One request is
// taken every cycle while the receiver does not stall; the decode is a single
// level of compare-and-select logic between the request and response registers.
// When the receiver stalls, the response register holds; the request register
// takes one more transfer only if it is empty, and req_tready is low while full.
// The control registers sit on the csr_ APB port (byte address 4 * index); the
// user must write them only while no access is in flight, as the block does
// not enforce it. Reset clears both stages and sets the control registers and
// the memory-configuration byte to their reset values.
module bus_address_decoder
   import busdec_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [REQ_DW-1:0] req_tdata,   // address[23:0], write_data[39:24]
   input  logic [REQ_UW-1:0] req_tuser,   // kind[0], is_word[1]
   // response channel
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // target[3:0], reg_index[7:4], ram_offset[31:8], local_data[47:32],
   // device_data[63:48], high_lane[64], access_fault[65], zero pad[71:66]
   output logic [RSP_DW-1:0] rsp_tdata,
   // control register port
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   logic [7:0]    mem_config_ff;
   logic [7:0]    mem_config_in;
   logic          s1_valid_ff;
   logic          s1_valid_in;
   req_item_type  s1_item_ff;
   logic          s2_valid_ff;
   logic          s2_valid_in;
   rsp_item_type  s2_item_ff;
   rsp_item_type  decoded;
   logic          memcfg_we;
   logic [7:0]    memcfg_wdata;
   logic          s2_load;
   logic          s1_load;
   logic          csr_write;
   csr_index_type csr_sel;

   // Control register writes
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_sel    = csr_index_type'(csr_paddr[CSR_AW-1:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_sel)
            CSR_RAM_SIZE:       cfg_in.ram_size       = csr_pwdata[ADDR_W-1:0];
            CSR_FAULT_CHECK_ON: cfg_in.fault_check_on = csr_pwdata[0];
            CSR_IS_STE:         cfg_in.is_ste         = csr_pwdata[0];
            CSR_IS_MEGA:        cfg_in.is_mega        = csr_pwdata[0];
            CSR_IS_TT:          cfg_in.is_tt          = csr_pwdata[0];
            CSR_HAS_RTC:        cfg_in.has_rtc        = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // Register read-back
   always_comb begin
      unique case (csr_sel)
         CSR_RAM_SIZE:       csr_prdata = {{(CSR_DW-ADDR_W){1'b0}}, cfg_ff.ram_size};
         CSR_FAULT_CHECK_ON: csr_prdata = {{(CSR_DW-1){1'b0}}, cfg_ff.fault_check_on};
         CSR_IS_STE:         csr_prdata = {{(CSR_DW-1){1'b0}}, cfg_ff.is_ste};
         CSR_IS_MEGA:        csr_prdata = {{(CSR_DW-1){1'b0}}, cfg_ff.is_mega};
         CSR_IS_TT:          csr_prdata = {{(CSR_DW-1){1'b0}}, cfg_ff.is_tt};
         CSR_HAS_RTC:        csr_prdata = {{(CSR_DW-1){1'b0}}, cfg_ff.has_rtc};
         default:            csr_prdata = '0;
      endcase
   end

   // Two-stage flow control: request register feeds the response register
   assign s2_load     = s1_valid_ff && (!s2_valid_ff || rsp_tready);
   assign s1_load     = req_tvalid && req_tready;
   assign req_tready  = !s1_valid_ff || s2_load;
   assign s1_valid_in = s1_load || (s1_valid_ff && !s2_load);
   assign s2_valid_in = s2_load || (s2_valid_ff && !rsp_tready);

   // Memory-config byte follows the decoded write as it moves on
   assign mem_config_in = (s2_load && memcfg_we) ? memcfg_wdata : mem_config_ff;

   busdec_decode u_decode (
      .item         (s1_item_ff),
      .cfg          (cfg_ff),
      .mem_config   (mem_config_ff),
      .result       (decoded),
      .memcfg_we    (memcfg_we),
      .memcfg_wdata (memcfg_wdata)
   );

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ram_size       <= RAM_SIZE_RESET;
         cfg_ff.fault_check_on <= FAULT_CHECK_ON_RESET;
         cfg_ff.is_ste         <= 1'b0;
         cfg_ff.is_mega        <= 1'b0;
         cfg_ff.is_tt          <= 1'b0;
         cfg_ff.has_rtc        <= 1'b0;
         mem_config_ff         <= '0;
         s1_valid_ff           <= 1'b0;
         s2_valid_ff           <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         mem_config_ff <= mem_config_in;
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s2_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_item_ff.kind       <= req_tuser[0];
         s1_item_ff.is_word    <= req_tuser[1];
         s1_item_ff.address    <= req_tdata[ADDR_W-1:0];
         s1_item_ff.write_data <= req_tdata[ADDR_W+DATA_W-1:ADDR_W];
      end
      if (s2_load) begin
         s2_item_ff <= decoded;
      end
   end

   // Response packing
   assign rsp_tvalid = s2_valid_ff;
   assign rsp_tdata  = {6'd0,
                        s2_item_ff.access_fault,
                        s2_item_ff.high_lane,
                        s2_item_ff.device_data,
                        s2_item_ff.local_data,
                        s2_item_ff.ram_offset,
                        s2_item_ff.reg_index,
                        s2_item_ff.target};

endmodule

// ----- rtl/busdec_checker.sv -----
module busdec_checker
   import busdec_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [RSP_DW-1:0] rsp_tdata
);

   logic [3:0] tgt;
   assign tgt = rsp_tdata[3:0];

   // A bus error never selects a device
   a_err_no_target: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[65] |-> tgt == TGT_NONE)
      else $error("bus error with a target selected");

   // Upper lane only for the serial interface registers
   a_lane_acia: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[64] |-> (tgt == TGT_ACIA0 || tgt == TGT_ACIA1))
      else $error("upper lane outside serial registers");

   // RAM offset is only set on RAM hits
   a_offset_ram: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[31:8] != 24'd0 |-> tgt == TGT_RAM)
      else $error("ram offset without ram target");

   // Nothing is offered right after reset
   a_reset_idle: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("response valid after reset");

   // A stalled transfer holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

endmodule

bind bus_address_decoder busdec_checker u_busdec_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
   import busdec_pkg::*;

   // Access direction and size as carried in req_tuser
   localparam logic ACCESS_READ  = 1'b0;
   localparam logic ACCESS_WRITE = 1'b1;
   localparam logic SIZE_BYTE    = 1'b0;
   localparam logic SIZE_WORD    = 1'b1;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned HOLD_CYCLES = 80;
   localparam int unsigned PHASES      = 8;
   localparam int unsigned PHASE_ITEMS = 115;

   // RAM limit selected by the low nibble of the memory config byte
   localparam logic [23:0] BANK_LIMIT [16] = '{
      24'h040000, 24'h080000, 24'h200000, 24'h800000,
      24'h080000, 24'h100000, 24'h280000, 24'h880000,
      24'h200000, 24'h280000, 24'h400000, 24'ha00000,
      24'h800000, 24'h880000, 24'ha00000, 24'hf00000
   };

   // I/O windows the random addresses are drawn from (base, span)
   localparam logic [23:0] IO_BASE [16] = '{
      24'hff8000, 24'hff8600, 24'hff8800, 24'hff8808,
      24'hff8900, 24'hff8940, 24'hff8a00, 24'hff8e00,
      24'hff9000, 24'hff9200, 24'hff9210, 24'hff9220,
      24'hfa0000, 24'hfffc00, 24'hfffc20, 24'hfffc40
   };
   localparam int unsigned IO_SPAN [16] = '{
      4, 16, 8, 248, 64, 16, 64, 18, 4, 4, 8, 4, 4, 8, 32, 4
   };

   typedef enum logic [1:0] {
      RX_STREAM,
      RX_RANDOM,
      RX_SPARSE
   } rx_mode_type;

   // Decode predictor plus the queue of decodes still owed by the block
   class access_scoreboard;
      cfg_type      settings;
      logic [7:0]   mem_config;
      rsp_item_type expected_decodes[$];
      int unsigned  mismatch_count;

      function new();
         settings.ram_size       = RAM_SIZE_RESET;
         settings.fault_check_on = FAULT_CHECK_ON_RESET;
         settings.is_ste         = 1'b0;
         settings.is_mega        = 1'b0;
         settings.is_tt          = 1'b0;
         settings.has_rtc        = 1'b0;
         mem_config              = 8'h00;
         mismatch_count          = 0;
      endfunction

      function void note_register_write(logic [2:0] idx, logic [31:0] value);
         case (csr_index_type'(idx))
            CSR_RAM_SIZE:       settings.ram_size       = value[23:0];
            CSR_FAULT_CHECK_ON: settings.fault_check_on = value[0];
            CSR_IS_STE:         settings.is_ste         = value[0];
            CSR_IS_MEGA:        settings.is_mega        = value[0];
            CSR_IS_TT:          settings.is_tt          = value[0];
            CSR_HAS_RTC:        settings.has_rtc        = value[0];
            default: ;
         endcase
      endfunction

      function bit in_window(logic [23:0] a, logic [23:0] lo, int unsigned span);
         return a >= lo && a < lo + span;
      endfunction

      function bit ste_byte_reg(logic [23:0] a);
         return a == 24'hff9000 || a == 24'hff9001 || in_window(a, 24'hff9200, 4) ||
                a == 24'hff9211 || a == 24'hff9213 || a == 24'hff9215 ||
                a == 24'hff9217 || in_window(a, 24'hff9220, 4);
      endfunction

      function bit ste_word_reg(logic [23:0] a);
         return a == 24'hff9000 || a == 24'hff9200 || a == 24'hff9202 ||
                a == 24'hff9220 || a == 24'hff9222;
      endfunction

      function bit vme_reg(logic [23:0] a);
         return a >= 24'hff8e01 && a <= 24'hff8e0f && a[0];
      endfunction

      function bit acia_reg(logic [23:0] a);
         return a >= 24'hfffc00 && a <= 24'hfffc06 && !a[0];
      endfunction

      // Works out the decode of one access; byte writes at the config
      // address update the config byte as they go
      function rsp_item_type decode_access(req_item_type acc);
         rsp_item_type r;
         logic [23:0]  a;
         logic [7:0]   lo_byte;
         logic [7:0]   hi_byte;
         bit           limit_ok;
         a       = acc.address;
         lo_byte = acc.write_data[7:0];
         hi_byte = acc.write_data[15:8];
         r       = '0;
         r.target = TGT_NONE;

         if (a < 24'hf00000) begin
            // RAM space: beyond the installed size, with fault checking on, check the bank limit
            limit_ok = 1'b1;
            if (a >= settings.ram_size && settings.fault_check_on)
               limit_ok = mem_config[7:4] == 4'h0 && a < BANK_LIMIT[mem_config[3:0]];
            if (!limit_ok) begin
               r.access_fault = 1'b1;
               if (acc.kind == ACCESS_READ)
                  r.local_data = (acc.is_word == SIZE_WORD) ? 16'hffff : 16'h00ff;
            end else if (a < settings.ram_size) begin
               r.target     = TGT_RAM;
               r.ram_offset = a;
               if (acc.kind == ACCESS_WRITE)
                  r.device_data = (acc.is_word == SIZE_WORD) ? acc.write_data
                                                             : {8'h00, lo_byte};
            end
         end else if (acc.kind == ACCESS_READ && acc.is_word == SIZE_BYTE) begin
            // byte reads
            if (in_window(a, 24'hff8900, 64)) r.access_fault = !settings.is_ste;
            else if (in_window(a, 24'hff8a00, 64)) r.access_fault = 1'b1;
            else if (in_window(a, 24'hfffc20, 32)) begin
               if (settings.is_mega || settings.has_rtc) begin
                  r.target    = TGT_RTC;
                  r.reg_index = a[4:1];
               end
            end
            else if (a == 24'hff8001) begin
               r.target     = TGT_MEMCFG;
               r.local_data = {8'h00, mem_config};
            end
            else if (a == 24'hff8609) begin r.target = TGT_DMA_ADDR; r.reg_index = 4'd0; end
            else if (a == 24'hff860b) begin r.target = TGT_DMA_ADDR; r.reg_index = 4'd1; end
            else if (a == 24'hff860d) begin r.target = TGT_DMA_ADDR; r.reg_index = 4'd2; end
            else if (a == 24'hff860e || a == 24'hff860f) ;
            else if (a == 24'hff8800) r.target = TGT_PSG_DATA;
            else if (a == 24'hff8802) r.target = TGT_PSG_SEL;
            else if (acia_reg(a)) begin
               r.target    = (a < 24'hfffc04) ? TGT_ACIA0 : TGT_ACIA1;
               r.reg_index = {3'b000, a[1]};
            end
            else if (vme_reg(a)) r.access_fault = !(settings.is_mega || settings.is_tt);
            else if (ste_byte_reg(a)) r.access_fault = !settings.is_ste;
            else r.access_fault = 1'b1;
         end else if (acc.kind == ACCESS_READ) begin
            // word reads
            if (in_window(a, 24'hff8900, 64)) r.access_fault = !settings.is_ste;
            else if (in_window(a, 24'hff8a00, 64)) r.access_fault = 1'b1;
            else if (a == 24'hfa0000 || a == 24'hfa0002) ;
            else if (a == 24'hff8604) r.target = TGT_DMA_DISK;
            else if (a == 24'hff8606) r.target = TGT_DMA_STAT;
            else if (a == 24'hff8608) begin r.target = TGT_DMA_ADDR; r.reg_index = 4'd0; end
            else if (a == 24'hff860a) begin r.target = TGT_DMA_ADDR; r.reg_index = 4'd1; end
            else if (a == 24'hff860c) begin r.target = TGT_DMA_ADDR; r.reg_index = 4'd2; end
            else if (a == 24'hff860e) ;
            else if (ste_word_reg(a)) r.access_fault = !settings.is_ste;
            else if (acia_reg(a)) begin
               r.target    = (a < 24'hfffc04) ? TGT_ACIA0 : TGT_ACIA1;
               r.reg_index = {3'b000, a[1]};
               r.high_lane = 1'b1;
            end
            else r.access_fault = 1'b1;
         end else if (acc.is_word == SIZE_BYTE) begin
            // byte writes
            if (a >= 24'hff8808 && a < 24'hff8900) r.access_fault = 1'b1;
            else if (in_window(a, 24'hff8900, 64)) r.access_fault = !settings.is_ste;
            else if (in_window(a, 24'hff8a00, 64)) r.access_fault = 1'b1;
            else if (in_window(a, 24'hfffc20, 32)) begin
               if (settings.is_mega || settings.has_rtc) begin
                  r.target      = TGT_RTC;
                  r.reg_index   = a[4:1];
                  r.device_data = {8'h00, lo_byte};
               end else begin
                  r.access_fault = 1'b1;
               end
            end
            else if (a == 24'hff8001) begin
               r.target      = TGT_MEMCFG;
               r.device_data = {8'h00, lo_byte};
               mem_config    = lo_byte;
            end
            else if (a == 24'hff8609 || a == 24'hff860b || a == 24'hff860d) begin
               r.target      = TGT_DMA_ADDR;
               r.reg_index   = (a == 24'hff8609) ? 4'd0 : (a == 24'hff860b) ? 4'd1 : 4'd2;
               r.device_data = {8'h00, lo_byte};
            end
            else if (a == 24'hff860e || a == 24'hff860f) ;
            else if (a == 24'hff8800 || a == 24'hff8804) begin
               r.target      = TGT_PSG_SEL;
               r.device_data = {8'h00, lo_byte};
            end
            else if (a == 24'hff8802 || a == 24'hff8806) begin
               r.target      = TGT_PSG_DATA;
               r.device_data = {8'h00, lo_byte};
            end
            else if (vme_reg(a)) r.access_fault = !settings.is_mega;
            else if (ste_byte_reg(a)) r.access_fault = !settings.is_ste;
            else if (acia_reg(a)) begin
               r.target      = (a < 24'hfffc04) ? TGT_ACIA0 : TGT_ACIA1;
               r.reg_index   = {3'b000, a[1]};
               r.device_data = {8'h00, lo_byte};
            end
            else r.access_fault = 1'b1;
         end else begin
            // word writes; byte-wide devices take the high byte
            if (a >= 24'hff8804 && a < 24'hff8900) r.access_fault = 1'b1;
            else if (in_window(a, 24'hff8900, 64)) r.access_fault = !settings.is_ste;
            else if (in_window(a, 24'hff8a00, 64)) r.access_fault = 1'b1;
            else if (a == 24'hff8604) begin
               r.target      = TGT_DMA_DISK;
               r.device_data = acc.write_data;
            end
            else if (a == 24'hff8606) begin
               r.target      = TGT_DMA_STAT;
               r.device_data = acc.write_data;
            end
            else if (a == 24'hff860e) ;
            else if (a == 24'hff8800) begin
               r.target      = TGT_PSG_SEL;
               r.device_data = {8'h00, hi_byte};
            end
            else if (a == 24'hff8802) begin
               r.target      = TGT_PSG_DATA;
               r.device_data = {8'h00, hi_byte};
            end
            else if (ste_word_reg(a)) r.access_fault = !settings.is_ste;
            else if (acia_reg(a)) begin
               r.target      = (a < 24'hfffc04) ? TGT_ACIA0 : TGT_ACIA1;
               r.reg_index   = {3'b000, a[1]};
               r.device_data = {8'h00, hi_byte};
            end
            else r.access_fault = 1'b1;
         end
         return r;
      endfunction

      function void note_access(req_item_type acc);
         expected_decodes.push_back(decode_access(acc));
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
         end
      endfunction

      function void check_decode(rsp_item_type got);
         rsp_item_type want;
         if (expected_decodes.size() == 0) begin
            $error("response transfer with no access outstanding");
            mismatch_count++;
            return;
         end
         want = expected_decodes.pop_front();
         compare_field("target", want.target, got.target);
         compare_field("reg_index", want.reg_index, got.reg_index);
         compare_field("ram_offset", want.ram_offset, got.ram_offset);
         compare_field("local_data", want.local_data, got.local_data);
         compare_field("device_data", want.device_data, got.device_data);
         compare_field("high_lane", want.high_lane, got.high_lane);
         compare_field("access_fault", want.access_fault, got.access_fault);
      endfunction

      function int unsigned pending();
         return expected_decodes.size();
      endfunction
   endclass

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_tvalid  = 1'b0;
   logic              req_tready;
   logic [REQ_DW-1:0] req_tdata   = '0;   // address[23:0], write_data[39:24]
   logic [REQ_UW-1:0] req_tuser   = '0;   // kind[0], is_word[1]
   logic              rsp_tvalid;
   logic              rsp_tready  = 1'b0;
   // target[3:0], reg_index[7:4], ram_offset[31:8], local_data[47:32],
   // device_data[63:48], high_lane[64], access_fault[65]
   logic [RSP_DW-1:0] rsp_tdata;
   logic              csr_psel    = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0] csr_paddr   = '0;
   logic [CSR_DW-1:0] csr_pwdata  = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   access_scoreboard scoreboard = new();

   int unsigned burst_left   = 0;
   int unsigned cycle_count  = 0;
   int unsigned hold_cycles  = 0;
   int unsigned mode_left    = 0;
   bit          hold_request = 1'b0;
   rx_mode_type rx_mode      = RX_STREAM;

   bus_address_decoder dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("bus_address_decoder: mismatch");
         $finish;
      end
   end

   // Receiver: changing stall pattern, plus a long hold when asked
   always @(posedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_cycles  = HOLD_CYCLES;
      end
      if (hold_cycles != 0) begin
         hold_cycles--;
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            rx_mode   = rx_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(10, 60);
         end else begin
            mode_left--;
         end
         case (rx_mode)
            RX_STREAM: rsp_tready <= 1'b1;
            RX_RANDOM: rsp_tready <= 1'($urandom_range(0, 1));
            default:   rsp_tready <= ($urandom_range(0, 4) == 0);
         endcase
      end
   end

   // Monitor: register writes, request and response transfers
   always @(posedge clock) begin
      rsp_item_type got;
      req_item_type acc;
      if (!reset) begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready)
            scoreboard.note_register_write(csr_paddr[4:2], csr_pwdata);
         if (rsp_tvalid && rsp_tready) begin
            got.target       = target_type'(rsp_tdata[3:0]);
            got.reg_index    = rsp_tdata[7:4];
            got.ram_offset   = rsp_tdata[31:8];
            got.local_data   = rsp_tdata[47:32];
            got.device_data  = rsp_tdata[63:48];
            got.high_lane    = rsp_tdata[64];
            got.access_fault = rsp_tdata[65];
            scoreboard.check_decode(got);
         end
         if (req_tvalid && req_tready) begin
            acc.kind       = req_tuser[0];
            acc.is_word    = req_tuser[1];
            acc.address    = req_tdata[23:0];
            acc.write_data = req_tdata[39:24];
            scoreboard.note_access(acc);
         end
      end
   end

   // One request transfer; the sender idles between bursts
   task automatic send_access(input logic kind, input logic size,
                              input logic [23:0] addr, input logic [15:0] data);
      req_tdata  <= {data, addr};
      req_tuser  <= {size, kind};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (burst_left != 0) begin
         burst_left--;
      end else if (!(hold_request || hold_cycles != 0)) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(0, 30);
      end
   endtask

   // Setup and access cycle of one register write; psel stays up
   task automatic csr_write(input csr_index_type idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
   endtask

   // Waits first so the monitor has logged the last accepted transfer
   task automatic wait_idle();
      @(posedge clock);
      while (scoreboard.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes every register; unused upper bits carry junk half the time
   task automatic configure(input logic [23:0] ram, input logic [4:0] flags);
      logic [31:0] junk;
      junk = ($urandom_range(0, 1) == 0) ? 32'h0 : $urandom;
      csr_write(CSR_RAM_SIZE, {junk[7:0], ram});
      csr_write(CSR_FAULT_CHECK_ON, {junk[31:1], flags[0]});
      csr_write(CSR_IS_STE, {junk[30:0], flags[1]});
      csr_write(CSR_IS_MEGA, {junk[29:0], 1'b0, flags[2]} | 32'h0);
      csr_write(CSR_IS_TT, {junk[31:1], flags[3]});
      csr_write(CSR_HAS_RTC, {junk[30:0], flags[4]});
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int unsigned pick;
      int unsigned slot;
      logic        kind;
      logic        size;
      logic [23:0] addr;
      logic [23:0] ram;
      logic [15:0] data;
      logic [4:0]  flags;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed accesses under the reset settings
      send_access(ACCESS_READ, SIZE_BYTE, 24'hff8001, 16'h0000);
      send_access(ACCESS_READ, SIZE_WORD, 24'h100000, 16'h0000);
      // unknown memory config fails every limit check
      send_access(ACCESS_WRITE, SIZE_BYTE, 24'hff8001, 16'hff1f);
      send_access(ACCESS_READ, SIZE_BYTE, 24'h0fffff, 16'h0000);
      send_access(ACCESS_READ, SIZE_BYTE, 24'h100000, 16'h0000);
      // config 15 never errors
      send_access(ACCESS_WRITE, SIZE_BYTE, 24'hff8001, 16'h000f);
      send_access(ACCESS_READ, SIZE_WORD, 24'he00000, 16'h0000);
      send_access(ACCESS_WRITE, SIZE_WORD, 24'hefffff, 16'hffff);
      send_access(ACCESS_WRITE, SIZE_BYTE, 24'h000000, 16'hffff);
      // cartridge word reads
      send_access(ACCESS_READ, SIZE_WORD, 24'hfa0000, 16'h0000);
      send_access(ACCESS_READ, SIZE_WORD, 24'hfa0002, 16'h0000);
      // clock without the clock chip: read is quiet, write errors
      send_access(ACCESS_READ, SIZE_BYTE, 24'hfffc21, 16'h0000);
      send_access(ACCESS_WRITE, SIZE_BYTE, 24'hfffc21, 16'h0077);
      // word access to a byte-only register
      send_access(ACCESS_READ, SIZE_WORD, 24'hff8001, 16'h0000);
      send_access(ACCESS_WRITE, SIZE_BYTE, 24'hff8609, 16'h1234);
      send_access(ACCESS_WRITE, SIZE_WORD, 24'hff8604, 16'hffff);
      send_access(ACCESS_READ, SIZE_WORD, 24'hff8606, 16'h0000);
      send_access(ACCESS_WRITE, SIZE_WORD, 24'hff8800, 16'habcd);
      send_access(ACCESS_READ, SIZE_BYTE, 24'hff8802, 16'h0000);
      send_access(ACCESS_READ, SIZE_WORD, 24'hfffc02, 16'h0000);
      send_access(ACCESS_WRITE, SIZE_WORD, 24'hfffc04, 16'h5a00);
      send_access(ACCESS_READ, SIZE_BYTE, 24'hff8e01, 16'h0000);
      send_access(ACCESS_READ, SIZE_WORD, 24'hff9000, 16'h0000);
      send_access(ACCESS_READ, SIZE_BYTE, 24'hffffff, 16'h0000);
      send_access(ACCESS_WRITE, SIZE_BYTE, 24'hff8001, 16'h0005);
      req_tvalid <= 1'b0;

      for (int phase = 0; phase < PHASES; phase++) begin
         wait_idle();
         case (phase)
            0: begin ram = 24'h100000; flags = 5'b00001; end
            1: begin ram = 24'h000000; flags = 5'b11111; end
            2: begin ram = 24'hf00000; flags = 5'b00100; end
            3: begin ram = 24'hffffff; flags = 5'b01011; end
            default: begin
               pick = $urandom_range(0, 2);
               if (pick == 0) ram = BANK_LIMIT[$urandom_range(0, 15)];
               else ram = 24'($urandom_range(0, 24'hf00000));
               flags = 5'($urandom);
            end
         endcase
         configure(ram, flags);

         // long receiver hold while the sender keeps offering
         if (phase == 2) hold_request = 1'b1;

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // pause the sender until the block has drained
            if (phase == 4 && n == 60) begin
               req_tvalid <= 1'b0;
               wait_idle();
            end
            kind = 1'($urandom);
            size = 1'($urandom);
            data = 16'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
               kind = ACCESS_WRITE;
               size = SIZE_BYTE;
               addr = 24'hff8001;
               if ($urandom_range(0, 3) != 0) data[7:0] = 8'($urandom_range(0, 15));
            end
            else if (pick < 14) addr = 24'($urandom);
            else if (pick < 26)
               addr = scoreboard.settings.ram_size + 24'($urandom_range(0, 7)) - 24'd4;
            else if (pick < 34)
               addr = BANK_LIMIT[$urandom_range(0, 15)] + 24'($urandom_range(0, 3)) - 24'd2;
            else if (pick < 44) addr = 24'($urandom_range(0, 24'hefffff));
            else if (pick < 50) addr = 24'($urandom_range(24'hf00000, 24'hffffff));
            else begin
               slot = $urandom_range(0, 15);
               addr = IO_BASE[slot] + 24'($urandom_range(0, IO_SPAN[slot] - 1));
            end
            send_access(kind, size, addr, data);
         end
         req_tvalid <= 1'b0;
      end

      wait_idle();
      if (scoreboard.mismatch_count == 0 && scoreboard.pending() == 0)
         $display("bus_address_decoder: match");
      else
         $display("bus_address_decoder: mismatch");
      $finish;
   end

endmodule
